[design/lr_pkg.sv]
`timescale 1ns / 1ps

package lr_pkg;

  // coordinate and field widths
  localparam int COORD_WIDTH = 16;
  localparam int ERR_W       = COORD_WIDTH + 1;
  localparam int CFG_W       = 11;
  localparam int ADDR_W      = 20;
  localparam int COLOUR_W    = 8;
  localparam int CMP_W       = (COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W;

  // stream payload widths, padded to whole bytes
  localparam int S_FIELDS_W  = 4 * COORD_WIDTH + COLOUR_W;
  localparam int S_DATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W  = 2 * COORD_WIDTH + COLOUR_W + 1 + ADDR_W;
  localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

  // config port
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(200);

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // one emitted pixel before clipping and addressing
  typedef struct packed {
    logic                produced;
    coord_t              x;
    coord_t              y;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } pix_t;

endpackage

[design/line_rasterizer_unit.sv]
`timescale 1ns / 1ps

// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+---------------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser req_type, tdata endpoints and colour
// m_axis    | out | m_axis_tvalid / m_axis_tready | tuser produced, tlast last_pixel, tdata pixel
// apb       | in  | psel / penable / pready      | screen_width at 0x0, screen_height at 0x4
//
// one transfer in, one transfer out, one item per cycle sustained while m_axis_tready is not held low
// the line state update and the address multiply each get a register
// the 11x11 multiply for row*width+column sets the second stage
// reset clears the line state (no line active) and loads a 320x200 screen
// a stalled output holds its transfer; the front stage keeps accepting until both stages are full

module line_rasterizer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // start_x, start_y, end_x, end_y, colour (lowest bits first)
  input  logic [lr_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel_x, pixel_y, pixel_colour, visible, pixel_address (lowest bits first)
  output logic [lr_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // produced
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lr_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import lr_pkg::*;

  // config registers
  logic [CFG_W-1:0] width_q, height_q;
  logic             cfg_write;

  // line state
  coord_t                 cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [1:0]      step_x_q, step_x_d, step_y_q, step_y_d;
  logic [COORD_WIDTH-1:0] major_q, major_d, minor_q, minor_d;
  logic [ERR_W-1:0]       err_q, err_d;
  logic [COORD_WIDTH-1:0] steps_q, steps_d;
  logic                   x_major_q, x_major_d;
  logic [COLOUR_W-1:0]    colour_q, colour_d;
  logic                   active_q, active_d;

  // pipeline control
  logic s1_valid_q, m_valid_q;
  logic adv1, adv2, in_fire;
  pix_t pix_q, pix_d;

  // second stage
  logic                       visible;
  logic [ADDR_W-1:0]          addr;
  logic [M_DATA_W-1:0]        m_data_q, m_data_d;
  logic                       m_user_q, m_last_q;

  // ---------------------------------------------------------------- config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SCREEN_WIDTH) begin
        width_q <= pwdata[CFG_W-1:0];
      end else begin
        height_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- handshake
  assign adv2          = !m_valid_q || m_axis_tready;
  assign adv1          = !s1_valid_q || adv2;
  assign s_axis_tready = adv1;
  assign in_fire       = s_axis_tvalid && adv1;

  // ---------------------------------------------------------------- stage 1: bresenham step
  always_comb begin
    coord_t                 sx, sy, ex, ey;
    logic signed [ERR_W-1:0] dx, dy;
    logic [COORD_WIDTH-1:0] ax, ay;
    logic [ERR_W-1:0]       err_sum;
    logic                   take;

    sx = s_axis_tdata[COORD_WIDTH-1:0];
    sy = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    ex = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    ey = s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];

    // deltas one bit wider than the coordinates so they never overflow
    dx = ERR_W'(ex) - ERR_W'(sx);
    dy = ERR_W'(ey) - ERR_W'(sy);
    ax = dx[ERR_W-1] ? COORD_WIDTH'(-dx) : COORD_WIDTH'(dx);
    ay = dy[ERR_W-1] ? COORD_WIDTH'(-dy) : COORD_WIDTH'(dy);

    err_sum = err_q + ERR_W'(minor_q);
    take    = err_sum >= ERR_W'(major_q);

    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    step_x_d  = step_x_q;
    step_y_d  = step_y_q;
    major_d   = major_q;
    minor_d   = minor_q;
    err_d     = err_q;
    steps_d   = steps_q;
    x_major_d = x_major_q;
    colour_d  = colour_q;
    active_d  = active_q;
    pix_d     = '0;

    if (s_axis_tuser == REQ_START) begin
      cur_x_d   = sx;
      cur_y_d   = sy;
      step_x_d  = dx[ERR_W-1] ? 2'sb11 : ((dx != '0) ? 2'sb01 : 2'sb00);
      step_y_d  = dy[ERR_W-1] ? 2'sb11 : ((dy != '0) ? 2'sb01 : 2'sb00);
      // ties go to x as the major axis
      x_major_d = ax >= ay;
      major_d   = x_major_d ? ax : ay;
      minor_d   = x_major_d ? ay : ax;
      err_d     = ERR_W'(major_d >> 1);
      steps_d   = major_d;
      colour_d  = s_axis_tdata[4*COORD_WIDTH+COLOUR_W-1:4*COORD_WIDTH];
      active_d  = major_d != '0;
      pix_d     = '{produced: 1'b1, x: sx, y: sy, colour: colour_d,
                    last: major_d == '0};
    end else if (active_q) begin
      err_d = take ? err_sum - ERR_W'(major_q) : err_sum;
      if (x_major_q) begin
        cur_x_d = cur_x_q + COORD_WIDTH'(step_x_q);
        if (take) begin
          cur_y_d = cur_y_q + COORD_WIDTH'(step_y_q);
        end
      end else begin
        cur_y_d = cur_y_q + COORD_WIDTH'(step_y_q);
        if (take) begin
          cur_x_d = cur_x_q + COORD_WIDTH'(step_x_q);
        end
      end
      steps_d  = steps_q - COORD_WIDTH'(1);
      active_d = steps_d != '0;
      pix_d    = '{produced: 1'b1, x: cur_x_d, y: cur_y_d, colour: colour_q,
                   last: steps_d == '0};
    end
    // a step with no line leaves a record of all zeros
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      step_x_q  <= '0;
      step_y_q  <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      err_q     <= '0;
      steps_q   <= '0;
      x_major_q <= 1'b0;
      colour_q  <= '0;
      active_q  <= 1'b0;
    end else if (in_fire) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      step_x_q  <= step_x_d;
      step_y_q  <= step_y_d;
      major_q   <= major_d;
      minor_q   <= minor_d;
      err_q     <= err_d;
      steps_q   <= steps_d;
      x_major_q <= x_major_d;
      colour_q  <= colour_d;
      active_q  <= active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv1) begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_q <= pix_d;
    end
  end

  // ---------------------------------------------------------------- stage 2: clip and address
  // negative coordinates are off screen; the unsigned compares handle the rest
  assign visible = pix_q.produced && !pix_q.x[COORD_WIDTH-1] && !pix_q.y[COORD_WIDTH-1] &&
                   (CMP_W'(unsigned'(pix_q.x)) < CMP_W'(width_q)) &&
                   (CMP_W'(unsigned'(pix_q.y)) < CMP_W'(height_q));

  // a visible row is below the height, so it fits the config width
  assign addr = visible
              ? ADDR_W'(CFG_W'(unsigned'(pix_q.y)) * width_q) +
                ADDR_W'(CFG_W'(unsigned'(pix_q.x)))
              : '0;

  always_comb begin
    m_data_d = '0;
    if (pix_q.produced) begin
      m_data_d = M_DATA_W'({addr, visible, pix_q.colour, pix_q.y, pix_q.x});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv2) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_q) begin
      m_data_q <= m_data_d;
      m_user_q <= pix_q.produced;
      m_last_q <= pix_q.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------- checks
  // an empty front stage always takes a transfer
  a_front_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready)
    else $error("front stage empty but input not ready");

  // a step with no line gives an all-zero result
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("empty result carries data");

  // an active line always has pixels left to emit
  a_active_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (steps_q != '0 && major_q != '0))
    else $error("active line with no steps left");

  // the last pixel of a line ends it
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && pix_d.last) |=> !active_q)
    else $error("line still active after its last pixel");

endmodule

[tb/sv/line_rasterizer_unit_tb.sv]
`timescale 1ns / 1ps

module line_rasterizer_unit_tb;
  import lr_pkg::*;

  localparam int CMAX = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int CMIN = -CMAX - 1;

  // one pixel transfer as seen on the master side
  typedef struct {
    logic                produced;
    coord_t              x;
    coord_t              y;
    logic [COLOUR_W-1:0] colour;
    logic                visible;
    logic [ADDR_W-1:0]   addr;
    logic                last;
  } pixel_res_t;

  // one request, optionally with a hand-written expected pixel
  typedef struct {
    logic                req;
    coord_t              sx;
    coord_t              sy;
    coord_t              ex;
    coord_t              ey;
    logic [COLOUR_W-1:0] colour;
    bit                  typed;
    pixel_res_t          want;
  } req_row_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_DUTY, STALL_HEAVY} stall_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow of the line engine
  logic [CFG_W-1:0]       scr_w = WIDTH_RESET;
  logic [CFG_W-1:0]       scr_h = HEIGHT_RESET;
  coord_t                 ln_x = '0;
  coord_t                 ln_y = '0;
  logic signed [1:0]      dir_x = '0;
  logic signed [1:0]      dir_y = '0;
  logic [COORD_WIDTH-1:0] major_len = '0;
  logic [COORD_WIDTH-1:0] minor_len = '0;
  logic [COORD_WIDTH-1:0] steps_left = '0;
  logic [ERR_W-1:0]       err_acc = '0;
  logic                   x_major = 1'b0;
  logic                   ln_active = 1'b0;
  logic [COLOUR_W-1:0]    ln_colour = '0;

  pixel_res_t pending_pixels[$];
  req_row_t   directed[$];
  pixel_res_t blank;
  int burst_left = 0;
  int n_requests = 0;
  int n_starts = 0;
  int n_checked = 0;
  int n_visible = 0;
  int n_ends = 0;
  int n_settings = 0;
  int n_errors = 0;
  int cfg_w[8] = '{1024, 1, 0, 2047, 0, 1, 1024, 320};
  int cfg_h[8] = '{1024, 1, 0, 2047, 0, 1024, 1, 200};

  line_rasterizer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // advance the shadow line by one request and return the pixel it yields
  function automatic pixel_res_t trace_pixel(req_row_t r);
    logic signed [COORD_WIDTH:0] dx, dy;
    logic [COORD_WIDTH:0]        ax, ay;
    pixel_res_t                  p;
    p = blank;
    if (r.req == REQ_START) begin
      // deltas one bit wider than the coordinates, so they never wrap
      dx = ERR_W'(r.ex) - ERR_W'(r.sx);
      dy = ERR_W'(r.ey) - ERR_W'(r.sy);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      ln_x = r.sx;
      ln_y = r.sy;
      dir_x = (dx < 0) ? -2'sd1 : ((dx > 0) ? 2'sd1 : 2'sd0);
      dir_y = (dy < 0) ? -2'sd1 : ((dy > 0) ? 2'sd1 : 2'sd0);
      x_major = (ax >= ay);  // a tie goes to x
      major_len = x_major ? ax[COORD_WIDTH-1:0] : ay[COORD_WIDTH-1:0];
      minor_len = x_major ? ay[COORD_WIDTH-1:0] : ax[COORD_WIDTH-1:0];
      err_acc = ERR_W'(major_len >> 1);
      steps_left = major_len;
      ln_colour = r.colour;
      ln_active = (steps_left != 0);
    end else if (!ln_active) begin
      return p;
    end else begin
      err_acc = err_acc + ERR_W'(minor_len);
      if (err_acc >= ERR_W'(major_len)) begin
        err_acc = err_acc - ERR_W'(major_len);
        if (x_major) ln_y = ln_y + COORD_WIDTH'(dir_y);
        else ln_x = ln_x + COORD_WIDTH'(dir_x);
      end
      if (x_major) ln_x = ln_x + COORD_WIDTH'(dir_x);
      else ln_y = ln_y + COORD_WIDTH'(dir_y);
      steps_left = steps_left - COORD_WIDTH'(1);
      ln_active = (steps_left != 0);
    end
    p.produced = 1'b1;
    p.x = ln_x;
    p.y = ln_y;
    p.colour = ln_colour;
    p.visible = (ln_x >= 0) && (ln_y >= 0) &&
                (int'(ln_x) < int'(scr_w)) && (int'(ln_y) < int'(scr_h));
    p.addr = p.visible ? ADDR_W'(int'(ln_y) * int'(scr_w) + int'(ln_x)) : '0;
    p.last = (steps_left == 0);
    return p;
  endfunction

  function automatic pixel_res_t mk_res(bit produced, int x, int y, int colour, bit vis,
                                        int addr, bit last);
    pixel_res_t p;
    p.produced = produced;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.colour = COLOUR_W'(colour);
    p.visible = vis;
    p.addr = ADDR_W'(addr);
    p.last = last;
    return p;
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  task automatic add_row(logic req, int sx, int sy, int ex, int ey, int colour, bit typed,
                         pixel_res_t want);
    req_row_t r;
    r.req = req;
    r.sx = coord_t'(sx);
    r.sy = coord_t'(sy);
    r.ex = coord_t'(ex);
    r.ey = coord_t'(ey);
    r.colour = COLOUR_W'(colour);
    r.typed = typed;
    r.want = want;
    directed.push_back(r);
  endtask

  // bursts of random length, random gaps with junk on the bus in between
  task automatic sender_pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) begin
          s_axis_tdata = S_DATA_W'({$urandom(), $urandom(), $urandom()});
          s_axis_tuser = 1'($urandom_range(1));
          @(negedge clk_i);
        end
      end
    end
    burst_left--;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_req(req_row_t r);
    pixel_res_t pred;
    sender_pace();
    s_axis_tdata = S_DATA_W'({r.colour, r.ey, r.ex, r.sy, r.sx});
    s_axis_tuser = r.req;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = trace_pixel(r);
    if (r.typed) pending_pixels.push_back(r.want);
    else pending_pixels.push_back(pred);
    n_requests++;
    if (r.req == REQ_START) n_starts++;
    @(negedge clk_i);
  endtask

  // stop sending and let every outstanding pixel drain
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(logic reg_sel, int value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_sel, 2'b00};
    pwdata = APB_DATA_W'(CFG_W'(value));
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == REG_SCREEN_WIDTH) scr_w = CFG_W'(value);
    else scr_h = CFG_W'(value);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // a start followed by steps: mostly the full line, sometimes cut short by the
  // next start, sometimes overrun into steps with no line
  task automatic random_line(int span_w, int span_h);
    req_row_t r;
    req_row_t s;
    int kind, reach, bx, by, len, n_steps, pick;
    kind = $urandom_range(99);
    r.req = REQ_START;
    r.colour = COLOUR_W'($urandom_range(255));
    r.typed = 1'b0;
    reach = (kind >= 70 && kind < 82) ? 64 : 8;
    bx = int'($urandom_range(span_w + 32)) - 16;
    by = int'($urandom_range(span_h + 32)) - 16;
    if (kind >= 82 && kind < 90) begin
      // hug the ends of the coordinate range
      if ($urandom_range(1)) bx = ($urandom_range(1)) ? CMAX - int'($urandom_range(12))
                                                       : CMIN + int'($urandom_range(12));
      if ($urandom_range(1)) by = ($urandom_range(1)) ? CMAX - int'($urandom_range(12))
                                                       : CMIN + int'($urandom_range(12));
    end
    r.sx = clamp_coord(bx);
    r.sy = clamp_coord(by);
    r.ex = clamp_coord(bx + int'($urandom_range(2 * reach)) - reach);
    r.ey = clamp_coord(by + int'($urandom_range(2 * reach)) - reach);
    if (kind >= 90) begin
      r.sx = COORD_WIDTH'($urandom());
      r.sy = COORD_WIDTH'($urandom());
      r.ex = COORD_WIDTH'($urandom());
      r.ey = COORD_WIDTH'($urandom());
    end
    len = (int'(r.ex) > int'(r.sx)) ? int'(r.ex) - int'(r.sx) : int'(r.sx) - int'(r.ex);
    if (int'(r.ey) - int'(r.sy) > len) len = int'(r.ey) - int'(r.sy);
    if (int'(r.sy) - int'(r.ey) > len) len = int'(r.sy) - int'(r.ey);
    pick = $urandom_range(99);
    if (kind >= 90) n_steps = $urandom_range(6);
    else if (pick < 70) n_steps = len;
    else if (pick < 85) n_steps = $urandom_range(len);
    else n_steps = len + $urandom_range(1, 3);
    send_req(r);
    repeat (n_steps) begin
      // step payload is ignored, so fill it with junk
      s.req = REQ_STEP;
      s.sx = COORD_WIDTH'($urandom());
      s.sy = COORD_WIDTH'($urandom());
      s.ex = COORD_WIDTH'($urandom());
      s.ey = COORD_WIDTH'($urandom());
      s.colour = COLOUR_W'($urandom_range(255));
      s.typed = 1'b0;
      send_req(s);
    end
  endtask

  // receiver back-pressure: a random mode is picked and held for a random stretch
  initial begin
    stall_mode_e mode;
    int          left;
    int          cnt;
    mode = STALL_NONE;
    left = 0;
    cnt = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(3));
        left = $urandom_range(30, 150);
      end
      left--;
      cnt++;
      case (mode)
        STALL_NONE: begin
          m_axis_tready = 1'b1;
        end
        STALL_RANDOM: begin
          m_axis_tready = ($urandom_range(99) < 60);
        end
        STALL_DUTY: begin
          m_axis_tready = (cnt % 4 != 0);
        end
        default: begin
          m_axis_tready = (cnt % 9 == 0);
        end
      endcase
    end
  end

  // check every pixel transfer against the oldest pending one
  always @(posedge clk_i) begin
    pixel_res_t got;
    pixel_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.produced = m_axis_tuser;
      got.x = m_axis_tdata[COORD_WIDTH-1:0];
      got.y = m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      got.colour = m_axis_tdata[2*COORD_WIDTH+COLOUR_W-1:2*COORD_WIDTH];
      got.visible = m_axis_tdata[2*COORD_WIDTH+COLOUR_W];
      got.addr = m_axis_tdata[2*COORD_WIDTH+COLOUR_W+ADDR_W:2*COORD_WIDTH+COLOUR_W+1];
      got.last = m_axis_tlast;
      if (pending_pixels.size() == 0) begin
        $error("pixel transfer with nothing pending: x %0d y %0d", got.x, got.y);
        n_errors++;
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (got.visible) n_visible++;
        if (got.last) n_ends++;
        if (got.produced !== want.produced) begin
          $error("produced: expected %0d, got %0d", want.produced, got.produced);
          n_errors++;
        end
        if (got.x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, got.x);
          n_errors++;
        end
        if (got.y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, got.y);
          n_errors++;
        end
        if (got.colour !== want.colour) begin
          $error("pixel_colour: expected %0d, got %0d", want.colour, got.colour);
          n_errors++;
        end
        if (got.visible !== want.visible) begin
          $error("visible: expected %0d, got %0d", want.visible, got.visible);
          n_errors++;
        end
        if (got.addr !== want.addr) begin
          $error("pixel_address: expected %0d, got %0d", want.addr, got.addr);
          n_errors++;
        end
        if (got.last !== want.last) begin
          $error("last_pixel: expected %0d, got %0d", want.last, got.last);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $error("watchdog expired with %0d pixels pending", pending_pixels.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    int target;
    blank = mk_res(0, 0, 0, 0, 0, 0, 0);
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part, reset screen of 320x200
    add_row(REQ_STEP, 0, 0, 0, 0, 0, 1, blank);               // step with no line after reset
    add_row(REQ_START, 5, 3, 5, 3, 'hAA, 1, mk_res(1, 5, 3, 'hAA, 1, 965, 1));  // single pixel
    add_row(REQ_STEP, -1, -1, -1, -1, 'hFF, 1, blank);       // line already finished
    add_row(REQ_START, 0, 0, 6, 2, 'h11, 0, blank);          // shallow, x major
    repeat (6) add_row(REQ_STEP, 0, 0, 0, 0, 0, 0, blank);
    add_row(REQ_START, 10, 10, 7, 17, 'h22, 0, blank);       // steep, x walking back
    repeat (3) add_row(REQ_STEP, 0, 0, 0, 0, 0, 0, blank);
    // restart mid-line, full-range diagonal (tie goes to x)
    add_row(REQ_START, CMIN, CMIN, CMAX, CMAX, 'hFF, 1, mk_res(1, CMIN, CMIN, 'hFF, 0, 0, 0));
    add_row(REQ_STEP, 0, 0, 0, 0, 0, 0, blank);
    add_row(REQ_START, CMAX, CMAX, CMIN, CMAX, 'h00, 1, mk_res(1, CMAX, CMAX, 0, 0, 0, 0));
    add_row(REQ_STEP, 0, 0, 0, 0, 0, 0, blank);
    // screen corner and the first clipped column and row
    add_row(REQ_START, 319, 199, 319, 199, 'h55, 1, mk_res(1, 319, 199, 'h55, 1, 63999, 1));
    add_row(REQ_START, 320, 0, 320, 0, 'h0F, 1, mk_res(1, 320, 0, 'h0F, 0, 0, 1));
    add_row(REQ_START, 0, 200, 0, 200, 'hF0, 1, mk_res(1, 0, 200, 'hF0, 0, 0, 1));
    add_row(REQ_START, 0, 0, 3, -3, 'h3C, 0, blank);         // diagonal up, on screen then clipped
    repeat (3) add_row(REQ_STEP, 0, 0, 0, 0, 0, 0, blank);
    add_row(REQ_STEP, 0, 0, 0, 0, 0, 1, blank);
    foreach (directed[i]) send_req(directed[i]);
    wait_idle();

    // random part, one screen setting per phase; every phase boundary drains first
    cfg_w[4] = $urandom_range(1, 1024);
    cfg_h[4] = $urandom_range(1, 1024);
    foreach (cfg_w[p]) begin
      apb_write(REG_SCREEN_WIDTH, cfg_w[p]);
      apb_write(REG_SCREEN_HEIGHT, cfg_h[p]);
      n_settings++;
      target = n_requests + 80;
      while (n_requests < target) begin
        if ($urandom_range(99) < 15) begin
          req_row_t noise;
          noise.req = 1'($urandom_range(1));
          noise.sx = COORD_WIDTH'($urandom());
          noise.sy = COORD_WIDTH'($urandom());
          noise.ex = COORD_WIDTH'($urandom());
          noise.ey = COORD_WIDTH'($urandom());
          noise.colour = COLOUR_W'($urandom_range(255));
          noise.typed = 1'b0;
          send_req(noise);
        end else begin
          random_line((cfg_w[p] < 16) ? 16 : cfg_w[p], (cfg_h[p] < 16) ? 16 : cfg_h[p]);
        end
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    $display("tb: %0d requests, %0d line starts, %0d screen settings from 0x0 to 2047x2047",
             n_requests, n_starts, n_settings);
    $display("tb: %0d pixels checked, %0d on screen, %0d line ends", n_checked, n_visible,
             n_ends);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
